// File: hdl/wfps_pkg.sv
`timescale 1ns / 1ps

package wfps_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_TARGET_DISTANCE = 3'd0;
   localparam logic [2:0] REG_REFERENCE_SPEED = 3'd1;
   localparam logic [2:0] REG_MAX_ADJUST      = 3'd2;
   localparam logic [2:0] REG_GAIN_P          = 3'd3;
   localparam logic [2:0] REG_GAIN_D          = 3'd4;
   localparam logic [2:0] REG_GAIN_I          = 3'd5;

   localparam logic [8:0] NO_ECHO_CM = 9'd120;

   localparam logic signed [13:0] INTEG_MAX = 14'sh1fff;
   localparam logic signed [13:0] INTEG_MIN = 14'sh2000;

   localparam logic signed [23:0] SPEED_LIMIT = 24'sd255;

   typedef struct packed {
      logic [8:0]         target_distance;
      logic [7:0]         reference_speed;
      logic [7:0]         max_adjust;
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_d;
      logic signed [15:0] gain_i;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_distance: 9'd30,
      reference_speed: 8'd150,
      max_adjust:      8'd100,
      gain_p:          16'sd563,
      gain_d:          16'sd307,
      gain_i:          16'sd0
   };

   typedef struct packed {
      logic signed [10:0] err;
      logic signed [11:0] diff;
      logic signed [13:0] integ;
   } terms_type;

endpackage

// File: hdl/wfps_csr.sv
`timescale 1ns / 1ps

module wfps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [wfps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wfps_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wfps_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output wfps_pkg::cfg_type                cfg
);

   wfps_pkg::cfg_type cfg_ff;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= wfps_pkg::CFG_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            wfps_pkg::REG_TARGET_DISTANCE: cfg_ff.target_distance <= csr_pwdata[8:0];
            wfps_pkg::REG_REFERENCE_SPEED: cfg_ff.reference_speed <= csr_pwdata[7:0];
            wfps_pkg::REG_MAX_ADJUST:      cfg_ff.max_adjust      <= csr_pwdata[7:0];
            wfps_pkg::REG_GAIN_P:          cfg_ff.gain_p          <= csr_pwdata[15:0];
            wfps_pkg::REG_GAIN_D:          cfg_ff.gain_d          <= csr_pwdata[15:0];
            wfps_pkg::REG_GAIN_I:          cfg_ff.gain_i          <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         wfps_pkg::REG_TARGET_DISTANCE: csr_prdata = {23'd0, cfg_ff.target_distance};
         wfps_pkg::REG_REFERENCE_SPEED: csr_prdata = {24'd0, cfg_ff.reference_speed};
         wfps_pkg::REG_MAX_ADJUST:      csr_prdata = {24'd0, cfg_ff.max_adjust};
         wfps_pkg::REG_GAIN_P:          csr_prdata = {{16{cfg_ff.gain_p[15]}}, cfg_ff.gain_p};
         wfps_pkg::REG_GAIN_D:          csr_prdata = {{16{cfg_ff.gain_d[15]}}, cfg_ff.gain_d};
         wfps_pkg::REG_GAIN_I:          csr_prdata = {{16{cfg_ff.gain_i[15]}}, cfg_ff.gain_i};
         default:                       csr_prdata = '0;
      endcase
   end

endmodule

// File: hdl/wfps_error.sv
`timescale 1ns / 1ps

module wfps_error #(
   parameter int INTEGRAL_PERIOD = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [8:0]           distance_cm,
   input  logic                 restart,
   input  logic [8:0]           target_distance,
   output wfps_pkg::terms_type  terms
);

   localparam int CW = $clog2(INTEGRAL_PERIOD + 1);
   localparam logic [CW-1:0] PERIOD_LAST = CW'(INTEGRAL_PERIOD);

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       count_base;
   logic signed [10:0]  prev_err_ff;
   logic signed [10:0]  prev_base;
   logic signed [13:0]  integ_ff;
   logic signed [13:0]  integ_base;
   logic signed [13:0]  integ_keep;
   logic signed [13:0]  integ_in;
   logic signed [14:0]  integ_sum;
   logic [8:0]          dist_eff;
   logic signed [10:0]  err;
   logic signed [11:0]  diff;
   logic                wrap;
   wfps_pkg::terms_type terms_ff;

   always_comb begin
      count_base = restart ? '0 : count_ff;
      prev_base  = restart ? '0 : prev_err_ff;
      integ_base = restart ? '0 : integ_ff;
      wrap       = (count_base == PERIOD_LAST);
      count_in   = wrap ? '0 : count_base + CW'(1);
      integ_keep = wrap ? '0 : integ_base;

      dist_eff = (distance_cm == 9'd0) ? wfps_pkg::NO_ECHO_CM : distance_cm;
      err      = $signed({2'b00, target_distance}) - $signed({2'b00, dist_eff});

      integ_sum = $signed({integ_keep[13], integ_keep}) + $signed({{4{err[10]}}, err});
      if (integ_sum[14] != integ_sum[13]) begin
         integ_in = integ_sum[14] ? wfps_pkg::INTEG_MIN : wfps_pkg::INTEG_MAX;
      end else begin
         integ_in = integ_sum[13:0];
      end

      diff = $signed({err[10], err}) - $signed({prev_base[10], prev_base});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prev_err_ff <= '0;
         integ_ff    <= '0;
      end else if (load) begin
         count_ff    <= count_in;
         prev_err_ff <= err;
         integ_ff    <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff.err   <= err;
         terms_ff.diff  <= diff;
         terms_ff.integ <= integ_in;
      end
   end

   assign terms = terms_ff;

endmodule

// File: hdl/wfps_mix.sv
`timescale 1ns / 1ps

module wfps_mix (
   input  logic                clock,
   input  logic                load,
   input  wfps_pkg::terms_type terms,
   input  wfps_pkg::cfg_type   cfg,
   output logic signed [8:0]   left_speed,
   output logic signed [8:0]   right_speed
);

   // product / 256, truncated toward zero
   function automatic logic signed [23:0] qdiv256(input logic signed [31:0] x);
      logic signed [31:0] adj;
      adj = x + (x[31] ? 32'sd255 : 32'sd0);
      return adj[31:8];
   endfunction

   function automatic logic signed [8:0] sat_speed(input logic signed [23:0] x);
      if (x > wfps_pkg::SPEED_LIMIT) begin
         return 9'sd255;
      end else if (x < -wfps_pkg::SPEED_LIMIT) begin
         return -9'sd255;
      end else begin
         return x[8:0];
      end
   endfunction

   logic signed [26:0] p_prod;
   logic signed [27:0] d_prod;
   logic signed [29:0] i_prod;
   logic signed [23:0] p_q;
   logic signed [23:0] d_q;
   logic signed [23:0] i_q;
   logic signed [23:0] max_pos;
   logic signed [23:0] max_neg;
   logic signed [23:0] p_cl;
   logic signed [23:0] corr;
   logic signed [23:0] ref_s;
   logic signed [8:0]  left_in;
   logic signed [8:0]  right_in;
   logic signed [8:0]  left_ff;
   logic signed [8:0]  right_ff;

   always_comb begin
      p_prod = 27'(cfg.gain_p) * 27'(terms.err);
      d_prod = 28'(cfg.gain_d) * 28'(terms.diff);
      i_prod = 30'(cfg.gain_i) * 30'(terms.integ);

      p_q = qdiv256($signed({{5{p_prod[26]}}, p_prod}));
      d_q = qdiv256($signed({{4{d_prod[27]}}, d_prod}));
      i_q = qdiv256($signed({{2{i_prod[29]}}, i_prod}));

      max_pos = $signed({16'd0, cfg.max_adjust});
      max_neg = -max_pos;
      if (p_q > max_pos) begin
         p_cl = max_pos;
      end else if (p_q < max_neg) begin
         p_cl = max_neg;
      end else begin
         p_cl = p_q;
      end

      corr     = p_cl + d_q + i_q;
      ref_s    = $signed({16'd0, cfg.reference_speed});
      right_in = sat_speed(ref_s + corr);
      left_in  = sat_speed(ref_s - corr);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign left_speed  = left_ff;
   assign right_speed = right_ff;

endmodule

// File: hdl/wall_follow_pid_steering.sv
`timescale 1ns / 1ps

// result path: a taken request passes the input register, state stage and result register to rsp_valid
// throughput: one transaction per cycle; the whole pipeline holds while a result is stalled
// stages: input register, error and integral state update, gain products and wheel clamps
// reset: synchronous, clears valid bits, error state and step count, loads register defaults

module wall_follow_pid_steering #(
   parameter int INTEGRAL_PERIOD = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [8:0]                       req_distance_cm,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [8:0]                rsp_left_speed,
   output logic signed [8:0]                rsp_right_speed,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [wfps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wfps_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wfps_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   wfps_pkg::cfg_type   cfg;
   wfps_pkg::terms_type terms;

   logic       advance;
   logic       in_valid_ff;
   logic       mid_valid_ff;
   logic       out_valid_ff;
   logic [8:0] dist_ff;
   logic       restart_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_valid;
         mid_valid_ff <= in_valid_ff;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         dist_ff    <= req_distance_cm;
         restart_ff <= req_restart;
      end
   end

   wfps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wfps_error #(
      .INTEGRAL_PERIOD (INTEGRAL_PERIOD)
   ) u_error (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && in_valid_ff),
      .distance_cm     (dist_ff),
      .restart         (restart_ff),
      .target_distance (cfg.target_distance),
      .terms           (terms)
   );

   wfps_mix u_mix (
      .clock       (clock),
      .load        (advance && mid_valid_ff),
      .terms       (terms),
      .cfg         (cfg),
      .left_speed  (rsp_left_speed),
      .right_speed (rsp_right_speed)
   );

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed != 9'sh100))
      else $error("left speed below -255");

   a_right_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_speed != 9'sh100))
      else $error("right speed below -255");

   a_mid_to_out: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && advance) |=> out_valid_ff)
      else $error("transaction lost between state stage and result register");

   a_in_to_mid: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> mid_valid_ff)
      else $error("transaction lost between input register and state stage");

endmodule

// File: bench/wfps_steer_check.sv
`timescale 1ns / 1ps

module wfps_steer_check
   import wfps_pkg::*;
#(
   parameter int INTEGRAL_PERIOD = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [8:0]              req_distance_cm,
   input  logic                    req_restart,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [8:0]       rsp_left_speed,
   input  logic signed [8:0]       rsp_right_speed,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic                    csr_pready,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output int                      outstanding,
   output int                      mismatch_count
);

   typedef struct {
      logic signed [8:0] left;
      logic signed [8:0] right;
   } wheel_pair_type;

   cfg_type            shadow_cfg;
   logic signed [10:0] prev_error;
   logic signed [13:0] integral_sum;
   int                 step_count;
   wheel_pair_type     expected_speeds[$];
   wheel_pair_type     oldest;

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // q8.8 gain times value, truncated toward zero
   function automatic int q88_scale(input logic signed [15:0] gain, input int x);
      longint prod;
      prod = longint'(gain) * longint'(x);
      return int'(prod / 256);
   endfunction

   function automatic void write_register(input logic [2:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_TARGET_DISTANCE: shadow_cfg.target_distance = value[8:0];
         REG_REFERENCE_SPEED: shadow_cfg.reference_speed = value[7:0];
         REG_MAX_ADJUST:      shadow_cfg.max_adjust      = value[7:0];
         REG_GAIN_P:          shadow_cfg.gain_p          = value[15:0];
         REG_GAIN_D:          shadow_cfg.gain_d          = value[15:0];
         REG_GAIN_I:          shadow_cfg.gain_i          = value[15:0];
         default: ;
      endcase
   endfunction

   function automatic wheel_pair_type predict_wheel_speeds(input logic [8:0] distance,
                                                           input logic restart);
      int             measured;
      int             err;
      int             p_term;
      int             d_term;
      int             i_term;
      int             correction;
      wheel_pair_type speeds;
      if (restart) begin
         prev_error   = '0;
         integral_sum = '0;
         step_count   = 0;
      end
      if (step_count == INTEGRAL_PERIOD) begin
         step_count   = 0;
         integral_sum = '0;
      end else
         step_count = step_count + 1;
      measured = (distance == '0) ? int'(NO_ECHO_CM) : int'(distance);
      err = int'(shadow_cfg.target_distance) - measured;
      integral_sum = 14'(clamp_int(int'(integral_sum) + err, int'(INTEG_MIN),
                                   int'(INTEG_MAX)));
      p_term = clamp_int(q88_scale(shadow_cfg.gain_p, err),
                         -int'(shadow_cfg.max_adjust), int'(shadow_cfg.max_adjust));
      d_term = q88_scale(shadow_cfg.gain_d, err - int'(prev_error));
      i_term = q88_scale(shadow_cfg.gain_i, int'(integral_sum));
      correction = p_term + d_term + i_term;
      speeds.right = 9'(clamp_int(int'(shadow_cfg.reference_speed) + correction,
                                  -int'(SPEED_LIMIT), int'(SPEED_LIMIT)));
      speeds.left  = 9'(clamp_int(int'(shadow_cfg.reference_speed) - correction,
                                  -int'(SPEED_LIMIT), int'(SPEED_LIMIT)));
      prev_error = 11'(err);
      return speeds;
   endfunction

   initial begin
      outstanding    = 0;
      mismatch_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg   = CFG_RESET;
         prev_error   = '0;
         integral_sum = '0;
         step_count   = 0;
         expected_speeds.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00)
            write_register(csr_paddr[CSR_ADDR_W-1:2], csr_pwdata);
         if (req_valid && !req_stall)
            expected_speeds.push_back(predict_wheel_speeds(req_distance_cm, req_restart));
         if (rsp_valid && !rsp_stall) begin
            if (expected_speeds.size() == 0) begin
               $error("rsp transaction arrived with no reading pending");
               mismatch_count = mismatch_count + 1;
            end else begin
               oldest = expected_speeds.pop_front();
               if (rsp_left_speed !== oldest.left) begin
                  $error("left_speed: expected %0d, actual %0d", oldest.left, rsp_left_speed);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_right_speed !== oldest.right) begin
                  $error("right_speed: expected %0d, actual %0d", oldest.right,
                         rsp_right_speed);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
      outstanding = expected_speeds.size();
   end

endmodule

// File: bench/tb_wall_follow_pid_steering.sv
`timescale 1ns / 1ps

module tb_wall_follow_pid_steering;
   import wfps_pkg::*;

   localparam int INTEGRAL_PERIOD    = 5;
   localparam int READINGS_PER_PHASE = 66;
   localparam int PHASES             = 8;
   localparam int LONG_HOLD_CYCLES   = 40;
   localparam int SETTLE_CYCLES      = 6;
   localparam logic [2:0] REG_UNUSED = 3'd6;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [8:0]            req_distance_cm;
   logic                  req_restart;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [8:0]     rsp_left_speed;
   logic signed [8:0]     rsp_right_speed;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int outstanding;
   int mismatch_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit long_hold_req;
   int readings_sent;
   int settings_applied;
   int cur_target;

   wall_follow_pid_steering #(
      .INTEGRAL_PERIOD(INTEGRAL_PERIOD)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_distance_cm (req_distance_cm),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   wfps_steer_check #(
      .INTEGRAL_PERIOD(INTEGRAL_PERIOD)
   ) u_steer_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_distance_cm (req_distance_cm),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .outstanding     (outstanding),
      .mismatch_count  (mismatch_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // result side: random stalls, or one long hold when asked
   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else
            rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic csr_write(input logic [2:0] index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input cfg_type s);
      csr_write(REG_TARGET_DISTANCE, CSR_DATA_W'(s.target_distance));
      csr_write(REG_REFERENCE_SPEED, CSR_DATA_W'(s.reference_speed));
      csr_write(REG_MAX_ADJUST, CSR_DATA_W'(s.max_adjust));
      csr_write(REG_GAIN_P, {{16{s.gain_p[15]}}, s.gain_p});
      csr_write(REG_GAIN_D, {{16{s.gain_d[15]}}, s.gain_d});
      csr_write(REG_GAIN_I, {{16{s.gain_i[15]}}, s.gain_i});
      cur_target = int'(s.target_distance);
      settings_applied = settings_applied + 1;
   endtask

   function automatic cfg_type make_settings(input int kind);
      cfg_type s;
      case (kind)
         0: begin
            // gentle gains, wall close by
            s.target_distance = 9'($urandom_range(15, 80));
            s.reference_speed = 8'($urandom_range(80, 200));
            s.max_adjust      = 8'($urandom);
            s.gain_p          = 16'(int'($urandom_range(0, 2048)) - 1024);
            s.gain_d          = 16'(int'($urandom_range(0, 2048)) - 1024);
            s.gain_i          = 16'(int'($urandom_range(0, 512)) - 256);
         end
         1: begin
            s.target_distance = 9'h1ff;
            s.reference_speed = 8'hff;
            s.max_adjust      = 8'hff;
            s.gain_p          = 16'h7fff;
            s.gain_d          = 16'h8000;
            s.gain_i          = 16'h7fff;
         end
         2: begin
            s.target_distance = 9'h000;
            s.reference_speed = 8'h00;
            s.max_adjust      = 8'h00;
            s.gain_p          = 16'h8000;
            s.gain_d          = 16'h7fff;
            s.gain_i          = 16'h8000;
         end
         default: begin
            s.target_distance = 9'($urandom);
            s.reference_speed = 8'($urandom);
            s.max_adjust      = 8'($urandom);
            s.gain_p          = 16'($urandom);
            s.gain_d          = 16'($urandom);
            s.gain_i          = 16'($urandom);
         end
      endcase
      return s;
   endfunction

   // mostly readings near the target, some lost echoes and wild values
   function automatic logic [8:0] next_distance();
      int pick;
      int d;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return 9'd0;
      if (pick < 30)
         return 9'($urandom);
      d = cur_target + int'($urandom_range(0, 40)) - 20;
      if (d < 0) d = 0;
      if (d > 511) d = 511;
      return 9'(d);
   endfunction

   // called at a falling edge, returns at a falling edge with valid possibly still high
   task automatic send_reading(input logic [8:0] distance, input logic restart);
      req_valid       <= 1'b1;
      req_distance_cm <= distance;
      req_restart     <= restart;
      do @(posedge clock); while (req_stall);
      readings_sent = readings_sent + 1;
      @(negedge clock);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      cfg_type probe_cfg;
      int      idle_plan[4];
      int      stall_plan[4];
      idle_plan  = '{0, 68, 0, 12};
      stall_plan = '{0, 0, 68, 12};
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_distance_cm    = '0;
      req_restart        = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      long_hold_req      = 1'b0;
      readings_sent      = 0;
      settings_applied   = 1;
      cur_target         = int'(CFG_RESET.target_distance);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers: lost echo, field extremes, zero error, restart
      send_reading(9'd0, 1'b0);
      send_reading(9'd1, 1'b0);
      send_reading(9'd511, 1'b0);
      send_reading(9'd30, 1'b0);
      send_reading(9'd255, 1'b0);
      send_reading(9'd256, 1'b0);
      send_reading(9'd0, 1'b1);
      send_reading(9'd29, 1'b0);
      send_reading(9'd31, 1'b0);
      send_reading(9'd120, 1'b0);
      send_reading(9'd0, 1'b0);
      wait_until_drained();

      // unmapped register write must leave the settings alone
      csr_write(REG_UNUSED, $urandom);
      probe_cfg.target_distance = 9'd100;
      probe_cfg.reference_speed = 8'd0;
      probe_cfg.max_adjust      = 8'd0;
      probe_cfg.gain_p          = 16'sd256;
      probe_cfg.gain_d          = -16'sd256;
      probe_cfg.gain_i          = 16'sd1000;
      apply_settings(probe_cfg);
      // zero p clamp, integral wraps across the period, restart midway
      send_reading(9'd100, 1'b1);
      send_reading(9'd511, 1'b0);
      send_reading(9'd1, 1'b0);
      send_reading(9'd0, 1'b0);
      send_reading(9'd200, 1'b0);
      send_reading(9'd50, 1'b0);
      send_reading(9'd100, 1'b0);
      send_reading(9'd300, 1'b1);
      send_reading(9'd7, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_drained();
         repeat (SETTLE_CYCLES) @(negedge clock);
         apply_settings(make_settings(phase % 4));
         sender_idle_pct    = idle_plan[phase % 4];
         receiver_stall_pct = stall_plan[phase % 4];
         for (int n = 0; n < READINGS_PER_PHASE; n++) begin
            if (n == 20 && phase % 4 == 0)
               long_hold_req = 1'b1;
            if (n == 40 && phase % 4 == 1)
               wait_until_drained();
            send_reading(next_distance(), $urandom_range(0, 39) == 0);
         end
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("run covered %0d readings under %0d register settings,", readings_sent,
               settings_applied);
      $display("pacing from back-to-back to mostly idle sender and mostly stalled receiver");
      if (mismatch_count == 0)
         $display("tb_wall_follow_pid_steering: clean");
      else
         $display("tb_wall_follow_pid_steering: errors");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("tb_wall_follow_pid_steering: errors");
      $finish;
   end

endmodule
